// ===== hw/rtl/pgd_pkg.sv =====
// ----------------------------------------------------------------------------
// pgd_pkg
// shared types and codes of the proximity gesture detector
// ----------------------------------------------------------------------------
package pgd_pkg;

  // zone count and fixed widths of the payload fields
  localparam int unsigned ZoneCount  = 5;
  localparam int unsigned ZoneW      = 3;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned BriW       = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLICK_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SWIPE_WINDOW  = 2'd1;

  // register reset values
  localparam logic [CfgW-1:0] ClickTimeoutRst = 16'd600;
  localparam logic [CfgW-1:0] SwipeWindowRst  = 16'd250;

  // zone event codes
  localparam logic [1:0] ZEV_NONE  = 2'd0;
  localparam logic [1:0] ZEV_START = 2'd1;
  localparam logic [1:0] ZEV_CLICK = 2'd2;
  localparam logic [1:0] ZEV_END   = 2'd3;

  // swipe event codes
  localparam logic [1:0] SEV_NONE  = 2'd0;
  localparam logic [1:0] SEV_RIGHT = 2'd1;
  localparam logic [1:0] SEV_LEFT  = 2'd2;

  localparam logic [BriW-1:0] BriFull = 8'd255;

  // request to the brightness divider
  typedef struct packed {
    logic            start;
    logic [CfgW-1:0] diff;
    logic [CfgW-1:0] divisor;
  } div_req_t;

  // answer of the brightness divider
  typedef struct packed {
    logic            done;
    logic [BriW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pgd_div.sv =====
// ----------------------------------------------------------------------------
// pgd_div
// serial divider for the dimming level: floor(255*diff/divisor), diff <= divisor
// ----------------------------------------------------------------------------
module pgd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pgd_pkg::div_req_t req_i,
  output pgd_pkg::div_rsp_t rsp_o
);
  import pgd_pkg::*;

  localparam int unsigned NumW  = CfgW + BriW;
  localparam int unsigned StepW = $clog2(BriW);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CfgW-1:0]  rem_q;
  logic [BriW-1:0]  low_q;
  logic [BriW-1:0]  quot_q;
  logic [CfgW-1:0]  dvs_q;

  logic [NumW-1:0]  num;
  logic [CfgW:0]    trial;
  logic [CfgW:0]    trial_sub;
  logic             qbit;

  // numerator 255*diff as a shift and subtract
  assign num = {req_i.diff, {BriW{1'b0}}} - NumW'(req_i.diff);

  // one restoring step: shift in the next numerator bit, try the divisor
  assign trial     = {rem_q, low_q[BriW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign qbit      = (trial >= {1'b0, dvs_q});

  // sequencer of the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(BriW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient < 256 so the top numerator bits start below the divisor
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= num[NumW-1:BriW];
      low_q  <= num[BriW-1:0];
      dvs_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= qbit ? trial_sub[CfgW-1:0] : trial[CfgW-1:0];
      low_q  <= {low_q[BriW-2:0], 1'b0};
      quot_q <= {quot_q[BriW-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== hw/rtl/proximity_gesture_detector_top.sv =====
// ----------------------------------------------------------------------------
// proximity_gesture_detector_top
// hover, click, hover end and swipe detection over proximity sample ticks
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  in      | input     | in_valid_i / in_stall_o  | zone_hits_i, now_ms_i
//  out     | output    | out_valid_o / out_stall_i| zone/swipe events, brightness
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one word in gives one word out; the block takes one word at a time
// a word runs through the calc and done states, and also through the div state
// when the dwell brightness runs through the 8-step serial divider
// a finished word waits in the result registers until the output register is
// free, so a stalled output only holds the next word once its own result is ready
// reset is asynchronous; configuration writes are taken in every cycle
// ----------------------------------------------------------------------------
module proximity_gesture_detector_top #(
  parameter int unsigned SWIPE_DEPTH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pgd_pkg::ZoneCount-1:0] zone_hits_i,
  input  logic [pgd_pkg::TimeW-1:0]     now_ms_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    zone_event_o,
  output logic [pgd_pkg::ZoneW-1:0]     zone_number_o,
  output logic [1:0]                    swipe_event_o,
  output logic [pgd_pkg::BriW-1:0]      brightness_o,
  output logic                          brightness_valid_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pgd_pkg::CfgW-1:0]      cfg_data_i
);
  import pgd_pkg::*;

  localparam int unsigned CntW = $clog2(SWIPE_DEPTH);
  localparam logic [CntW-1:0] CntMax = CntW'(SWIPE_DEPTH - 1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);
  localparam logic [ZoneW-1:0] ZoneTwo  = ZoneW'(2);
  localparam logic [ZoneW-1:0] ZoneNext = ZoneW'(ZoneCount - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // zone 1..5 when exactly one flag is set, else 0
  function automatic logic [ZoneW-1:0] single_zone(input logic [ZoneCount-1:0] z);
    logic [ZoneW-1:0] k;
    k = '0;
    unique case (z)
      5'b00001: k = 3'd1;
      5'b00010: k = 3'd2;
      5'b00100: k = 3'd3;
      5'b01000: k = 3'd4;
      5'b10000: k = 3'd5;
      default:  k = '0;
    endcase
    return k;
  endfunction

  logic [1:0]           state_q, state_d;
  logic [CfgW-1:0]      click_timeout_q;
  logic [CfgW-1:0]      swipe_window_q;
  logic [ZoneCount-1:0] zone_q;
  logic [TimeW-1:0]     now_q;

  // hover state
  logic             motion_q, motion_d;
  logic             hover_q, hover_d;
  logic [TimeW-1:0] hover_stamp_q, hover_stamp_d;
  logic             click_q, click_d;
  logic             end_rep_q, end_rep_d;
  logic [ZoneW-1:0] last_zone_q, last_zone_d;

  // swipe trackers
  logic             r_act_q, r_act_d, l_act_q, l_act_d;
  logic [CntW-1:0]  r_cnt_q, r_cnt_d, l_cnt_q, l_cnt_d;
  logic [TimeW-1:0] r_stamp_q, r_stamp_d, l_stamp_q, l_stamp_d;
  logic [ZoneW-1:0] r_zones_q [SWIPE_DEPTH];
  logic [ZoneW-1:0] l_zones_q [SWIPE_DEPTH];
  logic             r_zwe, l_zwe;

  // result held until the output register is free
  logic [1:0]       res_zev_q, res_zev_d;
  logic [ZoneW-1:0] res_znum_q, res_znum_d;
  logic [1:0]       res_sev_q, res_sev_d;
  logic [BriW-1:0]  res_bri_q, res_bri_d;
  logic             res_bval_q, res_bval_d;
  logic             need_div;
  logic [CfgW-1:0]  div_diff;

  // output register
  logic             out_valid_q;
  logic [1:0]       out_zev_q;
  logic [ZoneW-1:0] out_znum_q;
  logic [1:0]       out_sev_q;
  logic [BriW-1:0]  out_bri_q;
  logic             out_bval_q;

  logic [ZoneW-1:0] k;
  logic             idle_z;
  logic [TimeW-1:0] r_el, l_el, h_el;
  logic [TimeW-1:0] win32, cto32;
  logic             r_order, l_order;
  logic             rf, lf;
  logic             out_free;
  logic             in_acc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign k      = single_zone(zone_q);
  assign idle_z = (zone_q == '0);
  assign win32  = TimeW'(swipe_window_q);
  assign cto32  = TimeW'(click_timeout_q);
  assign r_el   = now_q - r_stamp_q;
  assign l_el   = now_q - l_stamp_q;
  assign h_el   = now_q - hover_stamp_q;

  assign r_order = (r_zones_q[0] < r_zones_q[1]) && (r_zones_q[1] < r_zones_q[2]);
  assign l_order = (l_zones_q[0] > l_zones_q[1]) && (l_zones_q[1] > l_zones_q[2]);

  // one tick of gesture logic: swipe checks, then hover
  always_comb begin
    r_act_d = r_act_q;  r_cnt_d = r_cnt_q;  r_stamp_d = r_stamp_q;
    l_act_d = l_act_q;  l_cnt_d = l_cnt_q;  l_stamp_d = l_stamp_q;
    r_zwe = 1'b0;  l_zwe = 1'b0;
    rf = 1'b0;  lf = 1'b0;
    motion_d = motion_q;  hover_d = hover_q;  hover_stamp_d = hover_stamp_q;
    click_d = click_q;  end_rep_d = end_rep_q;  last_zone_d = last_zone_q;
    res_zev_d = ZEV_NONE;  res_znum_d = '0;  res_sev_d = SEV_NONE;
    res_bri_d = '0;  res_bval_d = 1'b0;
    need_div = 1'b0;
    div_diff = click_timeout_q - h_el[CfgW-1:0];

    // right tracker check
    if (r_act_q) begin
      if (r_el > win32) begin
        r_act_d = 1'b0;
        r_cnt_d = '0;
      end else if (r_el < win32 && r_cnt_q >= CntTwo && r_order && idle_z) begin
        r_act_d = 1'b0;
        r_cnt_d = '0;
        rf = 1'b1;
      end
    end
    // left tracker check
    if (l_act_q) begin
      if (l_el > win32) begin
        l_act_d = 1'b0;
        l_cnt_d = '0;
      end else if (l_el < win32 && l_cnt_q >= CntTwo && l_order && idle_z) begin
        l_act_d = 1'b0;
        l_cnt_d = '0;
        lf = 1'b1;
      end
    end
    if (rf) begin
      res_sev_d = SEV_RIGHT;
    end else if (lf) begin
      res_sev_d = SEV_LEFT;
    end

    // hover logic
    if (motion_q) begin
      if (k != '0) begin
        if (!click_q) begin
          if (!hover_q) begin
            res_zev_d  = ZEV_START;
            res_znum_d = k;
            last_zone_d = k;
            res_bri_d  = BriFull;
            res_bval_d = 1'b1;
            if (r_act_d && k >= ZoneTwo) begin
              r_cnt_d   = (r_cnt_d < CntMax) ? r_cnt_d + CntW'(1) : CntMax;
              r_stamp_d = now_q;
              r_zwe     = 1'b1;
            end else if (!r_act_d && k <= ZoneTwo) begin
              r_act_d   = 1'b1;
              r_cnt_d   = '0;
              r_stamp_d = now_q;
              r_zwe     = 1'b1;
            end
            if (l_act_d && k <= ZoneNext) begin
              l_cnt_d   = (l_cnt_d < CntMax) ? l_cnt_d + CntW'(1) : CntMax;
              l_stamp_d = now_q;
              l_zwe     = 1'b1;
            end else if (!l_act_d && k >= ZoneNext) begin
              l_act_d   = 1'b1;
              l_cnt_d   = '0;
              l_stamp_d = now_q;
              l_zwe     = 1'b1;
            end
            hover_stamp_d = now_q;
            hover_d = 1'b1;
          end else if (h_el > cto32) begin
            res_zev_d  = ZEV_CLICK;
            res_znum_d = k;
            click_d    = 1'b1;
          end else begin
            res_bval_d = 1'b1;
            if (click_timeout_q == '0) begin
              res_bri_d = BriFull;
            end else begin
              need_div = 1'b1;
            end
          end
        end
      end else begin
        motion_d = 1'b0;
        hover_d  = 1'b0;
        if (!end_rep_q) begin
          end_rep_d = 1'b1;
          if (last_zone_q != '0) begin
            res_zev_d  = ZEV_END;
            res_znum_d = last_zone_q;
          end
        end
        res_bri_d  = '0;
        res_bval_d = 1'b1;
      end
    end else if (k != '0) begin
      motion_d  = 1'b1;
      end_rep_d = 1'b0;
    end else begin
      click_d   = 1'b0;
      end_rep_d = 1'b0;
    end
  end

  // divider request
  assign div_req.start   = (state_q == ST_CALC) && need_div;
  assign div_req.diff    = div_diff;
  assign div_req.divisor = click_timeout_q;

  pgd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CALC;
      ST_CALC: state_d = need_div ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_rsp.done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      click_timeout_q <= ClickTimeoutRst;
      swipe_window_q  <= SwipeWindowRst;
      motion_q        <= 1'b0;
      hover_q         <= 1'b0;
      click_q         <= 1'b0;
      end_rep_q       <= 1'b0;
      last_zone_q     <= '0;
      r_act_q         <= 1'b0;
      r_cnt_q         <= '0;
      l_act_q         <= 1'b0;
      l_cnt_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CLICK_TIMEOUT: click_timeout_q <= cfg_data_i;
          CFG_SWIPE_WINDOW:  swipe_window_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CALC) begin
        motion_q    <= motion_d;
        hover_q     <= hover_d;
        click_q     <= click_d;
        end_rep_q   <= end_rep_d;
        last_zone_q <= last_zone_d;
        r_act_q     <= r_act_d;
        r_cnt_q     <= r_cnt_d;
        l_act_q     <= l_act_d;
        l_cnt_q     <= l_cnt_d;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      zone_q <= zone_hits_i;
      now_q  <= now_ms_i;
    end
    if (state_q == ST_CALC) begin
      hover_stamp_q <= hover_stamp_d;
      r_stamp_q     <= r_stamp_d;
      l_stamp_q     <= l_stamp_d;
      res_zev_q     <= res_zev_d;
      res_znum_q    <= res_znum_d;
      res_sev_q     <= res_sev_d;
      res_bri_q     <= res_bri_d;
      res_bval_q    <= res_bval_d;
      if (r_zwe) r_zones_q[r_cnt_d] <= k;
      if (l_zwe) l_zones_q[l_cnt_d] <= k;
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      res_bri_q <= div_rsp.quot;
    end
    if (state_q == ST_DONE && out_free) begin
      out_zev_q  <= res_zev_q;
      out_znum_q <= res_znum_q;
      out_sev_q  <= res_sev_q;
      out_bri_q  <= res_bri_q;
      out_bval_q <= res_bval_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign zone_event_o       = out_zev_q;
  assign zone_number_o      = out_znum_q;
  assign swipe_event_o      = out_sev_q;
  assign brightness_o       = out_bri_q;
  assign brightness_valid_o = out_bval_q;

endmodule

// ===== hw/rtl/pgd_checker.sv =====
// ----------------------------------------------------------------------------
// pgd_checker
// port-level checks of the proximity gesture detector
// ----------------------------------------------------------------------------
module pgd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    zone_event_o,
  input logic [pgd_pkg::ZoneW-1:0]     zone_number_o,
  input logic [pgd_pkg::BriW-1:0]      brightness_o,
  input logic                          brightness_valid_o
);
  import pgd_pkg::*;

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // the block is busy in the cycle after it takes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while a word is in work");

  // no zone number without a zone event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zone_event_o == ZEV_NONE |-> zone_number_o == '0)
    else $error("zone number without zone event");

  // a zone event names a real zone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zone_event_o != ZEV_NONE |->
      zone_number_o != '0 && zone_number_o <= ZoneW'(ZoneCount))
    else $error("zone event with bad zone number");

  // brightness is zero when not updated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !brightness_valid_o |-> brightness_o == '0)
    else $error("brightness set without update flag");

endmodule

bind proximity_gesture_detector_top pgd_checker u_pgd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .zone_event_o       (zone_event_o),
  .zone_number_o      (zone_number_o),
  .brightness_o       (brightness_o),
  .brightness_valid_o (brightness_valid_o)
);
